// ===== rtl/twis_pkg.sv =====
// shared types, codes and constants of the irrigation window scheduler
package twis_pkg;

  localparam int SLOT_CAPACITY_DEF = 32;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  localparam int          ADDR_W      = 3;
  localparam logic [2:0]  ADDR_THRESH = 3'd0;
  localparam logic [9:0]  THRESH_RST  = 10'd600;

  // scan token handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic [31:0] now_time;
    logic        below;
    logic        pump_on;
    logic        inwin;
    logic        started;
    logic [15:0] minutes;
  } tok_t;

  // table write broadcast
  typedef struct packed {
    logic        load;
    logic        clr;
    logic [31:0] win_start;
    logic [31:0] win_end;
    logic [15:0] run;
  } wr_t;

  typedef struct packed {
    logic        pump_start;
    logic [15:0] pump_minutes;
    logic        in_window;
    logic [1:0]  load_status;
  } res_t;

endpackage

// ===== rtl/twis_req_if.sv =====
// request channel: valid/ready with the request fields
interface twis_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] now_time;
  logic [9:0]  soil_moisture;
  logic        pump_running;
  logic [31:0] window_start;
  logic [31:0] window_end;
  logic [15:0] run_minutes;

  modport source (output valid, mode, now_time, soil_moisture, pump_running,
                  window_start, window_end, run_minutes, input ready);
  modport sink (input valid, mode, now_time, soil_moisture, pump_running,
                window_start, window_end, run_minutes, output ready);
endinterface

// ===== rtl/twis_rsp_if.sv =====
// response channel: valid/ready with the result fields
interface twis_rsp_if;
  logic        valid;
  logic        ready;
  logic        pump_start;
  logic [15:0] pump_minutes;
  logic        in_window;
  logic [1:0]  load_status;

  modport source (output valid, pump_start, pump_minutes, in_window, load_status,
                  input ready);
  modport sink (input valid, pump_start, pump_minutes, in_window, load_status,
                output ready);
endinterface

// ===== rtl/timed_window_irrigation_scheduler.sv =====
// top level: request/response handling, config register and the slot chain
// Holds up to SLOT_CAPACITY watering windows, one per cell of a chain. Clear,
// load and unused-mode requests finish when accepted; their result is registered
// and moves to the response register once that is free. A tick sends a token
// through the chain, one cell per cycle, and keeps the block busy until the token
// leaves the last cell, so no request is taken meanwhile. The threshold register
// (address 0, reset 600) may be written only while the block is idle.
module timed_window_irrigation_scheduler #(
  parameter int SLOT_CAPACITY = twis_pkg::SLOT_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  twis_req_if.sink                    req,
  twis_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [twis_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import twis_pkg::*;

  localparam int CNT_W = $clog2(SLOT_CAPACITY + 1);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;
  logic [9:0]       soil_threshold;
  res_t             res;
  logic             res_valid;
  res_t             out_res;
  logic             out_valid;
  logic             accept;
  logic             out_load;
  logic             full;
  logic             zero_ts;
  wr_t              wr;
  tok_t             tok [SLOT_CAPACITY+1];
  logic [SLOT_CAPACITY-1:0] tok_vld;

  assign req.ready = (state == S_IDLE) && !res_valid;
  assign accept    = req.valid && req.ready;
  assign out_load  = res_valid && (!out_valid || rsp.ready);
  assign full      = count >= CNT_W'(SLOT_CAPACITY);
  assign zero_ts   = (req.window_start == 32'd0) || (req.window_end == 32'd0);

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_THRESH) ? {22'd0, soil_threshold} : 32'd0;

  assign wr.load      = accept && (req.mode == MODE_LOAD) && !full && !zero_ts;
  assign wr.clr       = accept && (req.mode == MODE_CLEAR);
  assign wr.win_start = req.window_start;
  assign wr.win_end   = req.window_end;
  assign wr.run       = req.run_minutes;

  assign tok[0].vld      = accept && (req.mode == MODE_TICK);
  assign tok[0].now_time = req.now_time;
  assign tok[0].below    = req.soil_moisture < soil_threshold;
  assign tok[0].pump_on  = req.pump_running;
  assign tok[0].inwin    = 1'b0;
  assign tok[0].started  = 1'b0;
  assign tok[0].minutes  = 16'd0;

  for (genvar i = 0; i < SLOT_CAPACITY; i++) begin : g_cell
    twis_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .count (count),
      .wr    (wr),
      .tin   (tok[i]),
      .tout  (tok[i+1])
    );
    assign tok_vld[i] = tok[i+1].vld;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
    if (accept) begin
      res <= '{pump_start: 1'b0, pump_minutes: 16'd0, in_window: 1'b0,
               load_status: (req.mode != MODE_LOAD) ? STATUS_OK :
                            (full ? STATUS_FULL : (zero_ts ? STATUS_ZERO : STATUS_OK))};
    end
    if (tok[SLOT_CAPACITY].vld) begin
      res.pump_start   <= tok[SLOT_CAPACITY].started;
      res.pump_minutes <= tok[SLOT_CAPACITY].minutes;
      res.in_window    <= tok[SLOT_CAPACITY].inwin;
      res.load_status  <= STATUS_OK;
    end
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      soil_threshold <= THRESH_RST;
      res_valid      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr == ADDR_THRESH)) begin
        soil_threshold <= pwdata[9:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
        res_valid <= 1'b0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        case (req.mode)
          MODE_CLEAR: begin
            count     <= '0;
            res_valid <= 1'b1;
          end
          MODE_LOAD: begin
            if (!full && !zero_ts) begin
              count <= count + CNT_W'(1);
            end
            res_valid <= 1'b1;
          end
          MODE_TICK: begin
            state <= S_SCAN;
          end
          default: begin
            res_valid <= 1'b1;
          end
        endcase
      end
      if (tok[SLOT_CAPACITY].vld) begin
        state     <= S_IDLE;
        res_valid <= 1'b1;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.pump_start   = out_res.pump_start;
  assign rsp.pump_minutes = out_res.pump_minutes;
  assign rsp.in_window    = out_res.in_window;
  assign rsp.load_status  = out_res.load_status;

  // at most one scan token in flight
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vld))
    else $error("more than one scan token in the chain");

  // tokens only travel while a scan is in progress
  a_token_scan: assert property (@(posedge clk) disable iff (rst)
    (tok_vld != '0) |-> (state == S_SCAN))
    else $error("scan token outside of a scan");

  // table never holds more windows than it has cells
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOT_CAPACITY))
    else $error("window count above capacity");

  // a finished scan always leaves a pending response
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    tok[SLOT_CAPACITY].vld |=> res_valid && (state == S_IDLE))
    else $error("scan finished without a response");

endmodule

// ===== rtl/twis_cell.sv =====
// one window slot of the scan chain
module twis_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CNT_W-1:0]   count,
  input  twis_pkg::wr_t      wr,
  input  twis_pkg::tok_t     tin,
  output twis_pkg::tok_t     tout
);
  import twis_pkg::*;

  logic [31:0] win_start;
  logic [31:0] win_end;
  logic [15:0] run;
  logic        done;
  logic        hit;
  logic        take;
  tok_t        tok_next;

  assign hit  = tin.vld && (CNT_W'(IDX) < count) &&
                (tin.now_time >= win_start) && (tin.now_time < win_end);
  assign take = hit && !tin.pump_on && !tin.started && !done;

  always_comb begin
    tok_next = tin;
    if (hit) begin
      tok_next.inwin = 1'b1;
    end
    if (take && tin.below) begin
      tok_next.started = 1'b1;
      tok_next.minutes = run;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.load && (count == CNT_W'(IDX))) begin
      win_start <= wr.win_start;
      win_end   <= wr.win_end;
      run       <= wr.run;
    end
    tout.now_time <= tok_next.now_time;
    tout.below    <= tok_next.below;
    tout.pump_on  <= tok_next.pump_on;
    tout.inwin    <= tok_next.inwin;
    tout.started  <= tok_next.started;
    tout.minutes  <= tok_next.minutes;
    if (rst) begin
      done     <= 1'b0;
      tout.vld <= 1'b0;
    end else begin
      tout.vld <= tin.vld;
      if (wr.clr || (wr.load && (count == CNT_W'(IDX)))) begin
        done <= 1'b0;
      end else if (take) begin
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of the timed-window irrigation scheduler
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import twis_pkg::*;

  localparam int SLOTS = SLOT_CAPACITY_DEF;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_time;
    logic [9:0]  soil;
    logic        pump_on;
    logic [31:0] win_start;
    logic [31:0] win_end;
    logic [15:0] minutes;
  } request_t;

  typedef struct packed {
    request_t   req;
    logic [5:0] reps;
    logic       fixed;
    res_t       want;
  } row_t;

  localparam res_t NONE     = '0;
  localparam res_t FULL_ST  = '{1'b0, 16'd0, 1'b0, STATUS_FULL};
  localparam res_t ZERO_ST  = '{1'b0, 16'd0, 1'b0, STATUS_ZERO};
  localparam res_t IN_ONLY  = '{1'b0, 16'd0, 1'b1, STATUS_OK};
  localparam res_t START_7  = '{1'b1, 16'd7, 1'b1, STATUS_OK};
  localparam res_t START_11 = '{1'b1, 16'd11, 1'b1, STATUS_OK};

  // threshold is 600 from reset during this part
  localparam row_t DIRECTED [25] = '{
    '{'{MODE_TICK,  32'd100, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, NONE},
    '{'{MODE_SPARE, 32'hFFFF_FFFF, 10'd1000, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        16'hFFFF}, 6'd1, 1'b1, NONE},
    '{'{MODE_LOAD,  32'd0, 10'd0, 1'b0, 32'd0, 32'd50, 16'd3}, 6'd1, 1'b1, ZERO_ST},
    '{'{MODE_LOAD,  32'd0, 10'd0, 1'b0, 32'd10, 32'd0, 16'd3}, 6'd1, 1'b1, ZERO_ST},
    '{'{MODE_LOAD,  32'd0, 10'd0, 1'b0, 32'd1, 32'hFFFF_FFFF, 16'hFFFF}, 6'd1, 1'b1, NONE},
    '{'{MODE_TICK,  32'd0, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, NONE},
    '{'{MODE_TICK,  32'hFFFF_FFFF, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, NONE},
    '{'{MODE_TICK,  32'hFFFF_FFFE, 10'd1000, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1,
        IN_ONLY},
    '{'{MODE_TICK,  32'd5, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, IN_ONLY},
    '{'{MODE_CLEAR, 32'd0, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, NONE},
    '{'{MODE_LOAD,  32'd0, 10'd0, 1'b0, 32'd100, 32'd200, 16'd7}, 6'd1, 1'b1, NONE},
    '{'{MODE_LOAD,  32'd0, 10'd0, 1'b0, 32'd300, 32'd300, 16'd9}, 6'd1, 1'b1, NONE},
    '{'{MODE_LOAD,  32'd0, 10'd0, 1'b0, 32'd150, 32'd250, 16'd11}, 6'd1, 1'b1, NONE},
    '{'{MODE_TICK,  32'd300, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, NONE},
    '{'{MODE_TICK,  32'd160, 10'd599, 1'b1, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, IN_ONLY},
    '{'{MODE_TICK,  32'd160, 10'd599, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, START_7},
    '{'{MODE_TICK,  32'd160, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, START_11},
    '{'{MODE_TICK,  32'd160, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, IN_ONLY},
    '{'{MODE_LOAD,  32'd0, 10'd0, 1'b0, 32'd400, 32'd500, 16'h8001}, 6'd29, 1'b1, NONE},
    '{'{MODE_LOAD,  32'd0, 10'd0, 1'b0, 32'd10, 32'd20, 16'd5}, 6'd1, 1'b1, FULL_ST},
    '{'{MODE_LOAD,  32'd0, 10'd0, 1'b0, 32'd0, 32'd0, 16'd5}, 6'd1, 1'b1, FULL_ST},
    '{'{MODE_TICK,  32'd450, 10'd599, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b0, NONE},
    '{'{MODE_TICK,  32'd450, 10'd600, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b0, NONE},
    '{'{MODE_TICK,  32'd450, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b0, NONE},
    '{'{MODE_CLEAR, 32'd0, 10'd0, 1'b0, 32'd0, 32'd0, 16'd0}, 6'd1, 1'b1, NONE}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  twis_req_if req_ch ();
  twis_rsp_if rsp_ch ();

  timed_window_irrigation_scheduler dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // own copy of the window table
  logic [31:0]      win_lo [SLOTS];
  logic [31:0]      win_hi [SLOTS];
  logic [15:0]      win_run [SLOTS];
  logic [SLOTS-1:0] win_done;
  int               win_used;
  logic [9:0]       thresh_model;

  res_t pending_outcomes [$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   calm = 1'b0;
  int   stall_asked = 0;
  int   stall_served = 0;
  logic offered_fixed;
  res_t offered_want;

  function automatic bit covers(int slot, logic [31:0] t);
    return t >= win_lo[slot] && t < win_hi[slot];
  endfunction

  function automatic res_t plan_watering(request_t r);
    res_t o;
    int i;
    o = '0;
    case (r.mode)
      MODE_CLEAR: begin
        win_used = 0;
        win_done = '0;
      end
      MODE_LOAD: begin
        if (win_used >= SLOTS) begin
          o.load_status = STATUS_FULL;
        end else if (r.win_start == 0 || r.win_end == 0) begin
          o.load_status = STATUS_ZERO;
        end else begin
          win_lo[win_used] = r.win_start;
          win_hi[win_used] = r.win_end;
          win_run[win_used] = r.minutes;
          win_done[win_used] = 1'b0;
          win_used++;
        end
      end
      MODE_TICK: begin
        for (i = 0; i < win_used; i++)
          if (covers(i, r.now_time)) o.in_window = 1'b1;
        if (!r.pump_on) begin
          for (i = 0; i < win_used && !o.pump_start; i++) begin
            if (!win_done[i] && covers(i, r.now_time)) begin
              win_done[i] = 1'b1;
              if (r.soil < thresh_model) begin
                o.pump_start = 1'b1;
                o.pump_minutes = win_run[i];
              end
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // scoreboard: responses checked first, then the accepted request is predicted
  always @(posedge clk) begin
    res_t want;
    request_t seen;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("response with no request outstanding");
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("pump_start", 32'(want.pump_start), 32'(rsp_ch.pump_start));
          check_field("pump_minutes", 32'(want.pump_minutes), 32'(rsp_ch.pump_minutes));
          check_field("in_window", 32'(want.in_window), 32'(rsp_ch.in_window));
          check_field("load_status", 32'(want.load_status), 32'(rsp_ch.load_status));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        seen = '{req_ch.mode, req_ch.now_time, req_ch.soil_moisture, req_ch.pump_running,
                 req_ch.window_start, req_ch.window_end, req_ch.run_minutes};
        want = plan_watering(seen);
        if (offered_fixed) want = offered_want;
        pending_outcomes.push_back(want);
      end
    end
  end

  // response sink with random back-pressure and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_asked != stall_served) begin
        stall_served++;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic offer(request_t r, logic fixed, res_t want);
    while (!calm && $urandom_range(99) < 18) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= r.mode;
    req_ch.now_time <= r.now_time;
    req_ch.soil_moisture <= r.soil;
    req_ch.pump_running <= r.pump_on;
    req_ch.window_start <= r.win_start;
    req_ch.window_end <= r.win_end;
    req_ch.run_minutes <= r.minutes;
    offered_fixed <= fixed;
    offered_want <= want;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic write_threshold(logic [9:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_THRESH;
    pwdata <= {22'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thresh_model = value;
  endtask

  // let the clock advance first so the last accepted request is already queued
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic request_t noise();
    request_t r;
    r.mode = 2'($urandom_range(3));
    r.now_time = $urandom;
    r.soil = 10'($urandom_range(1000));
    r.pump_on = 1'($urandom_range(1));
    r.win_start = $urandom;
    r.win_end = $urandom;
    r.minutes = 16'($urandom);
    return r;
  endfunction

  // optionally clear, fill the table around a base time, tick through that span, sometimes add a random request
  task automatic run_schedules(int budget);
    request_t r;
    logic [31:0] base;
    int counted, n, k;
    counted = 0;
    while (counted < budget) begin
      base = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 20000);
      if ($urandom_range(3) != 0) begin
        r = noise();
        r.mode = MODE_CLEAR;
        offer(r, 1'b0, NONE);
        counted++;
      end
      n = $urandom_range(1, 36);
      for (k = 0; k < n; k++) begin
        r = noise();
        r.mode = MODE_LOAD;
        r.win_start = base + $urandom_range(0, 200);
        r.win_end = r.win_start + $urandom_range(0, 120);
        case ($urandom_range(19))
          0: r.win_start = 0;
          1: r.win_end = 0;
          2: r.win_end = r.win_start - $urandom_range(1, 50);
          default: ;
        endcase
        if ($urandom_range(1)) r.minutes = 16'($urandom_range(1, 120));
        offer(r, 1'b0, NONE);
        counted++;
      end
      n = $urandom_range(2, 16);
      for (k = 0; k < n; k++) begin
        r = noise();
        r.mode = MODE_TICK;
        r.now_time = base + $urandom_range(0, 330) - 5;
        r.pump_on = ($urandom_range(99) < 15);
        case ($urandom_range(7))
          0: r.soil = thresh_model;
          1: if (thresh_model != 0) r.soil = thresh_model - 10'd1;
          default: ;
        endcase
        offer(r, 1'b0, NONE);
        counted++;
      end
      if ($urandom_range(4) == 0) begin
        r = noise();
        counted++;
        offer(r, 1'b0, NONE);
      end
    end
  endtask

  initial begin
    logic [9:0] settings [PHASES];
    int row, rep, phase;
    settings = '{10'd0, 10'd1000, 10'd600, 10'd1, 10'd999, 10'd0, 10'd0, 10'd300};
    settings[5] = 10'($urandom_range(1000));
    settings[6] = 10'($urandom_range(1000));
    win_used = 0;
    win_done = '0;
    thresh_model = THRESH_RST;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    offered_fixed <= 1'b0;
    offered_want <= NONE;
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_CLEAR;
    req_ch.now_time <= '0;
    req_ch.soil_moisture <= '0;
    req_ch.pump_running <= 1'b0;
    req_ch.window_start <= '0;
    req_ch.window_end <= '0;
    req_ch.run_minutes <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < $size(DIRECTED); row++)
      for (rep = 0; rep < DIRECTED[row].reps; rep++)
        offer(DIRECTED[row].req, DIRECTED[row].fixed, DIRECTED[row].want);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      write_threshold(settings[phase]);
      calm = (phase == 2);
      // receiver holds off while requests keep coming
      if (phase == 5) stall_asked++;
      run_schedules(PHASE_ITEMS);
      drain();
    end
    calm = 1'b0;

    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
